FILE: hdl/owbm_pkg.sv
package owbm_pkg;

  localparam int unsigned TIMER_WIDTH_DEF = 16;
  localparam int unsigned CFG_DATA_W      = 16;
  localparam int unsigned CFG_INDEX_W     = 3;

  localparam logic [1:0] REQ_TICK  = 2'd0;
  localparam logic [1:0] REQ_RESET = 2'd1;
  localparam logic [1:0] REQ_WRITE = 2'd2;
  localparam logic [1:0] REQ_READ  = 2'd3;

  localparam logic [CFG_INDEX_W-1:0] CFG_PRE_RESET      = 3'd0;
  localparam logic [CFG_INDEX_W-1:0] CFG_RESET_LOW      = 3'd1;
  localparam logic [CFG_INDEX_W-1:0] CFG_PRESENCE_DELAY = 3'd2;
  localparam logic [CFG_INDEX_W-1:0] CFG_PRESENCE_TOUT  = 3'd3;
  localparam logic [CFG_INDEX_W-1:0] CFG_RESET_TAIL     = 3'd4;
  localparam logic [CFG_INDEX_W-1:0] CFG_SLOT_LOW       = 3'd5;
  localparam logic [CFG_INDEX_W-1:0] CFG_SLOT_HOLD      = 3'd6;
  localparam logic [CFG_INDEX_W-1:0] CFG_READ_SAMPLE    = 3'd7;

  localparam logic [15:0] PRE_RESET_RST      = 16'd50;
  localparam logic [15:0] RESET_LOW_RST      = 16'd500;
  localparam logic [15:0] PRESENCE_DELAY_RST = 16'd40;
  localparam logic [15:0] PRESENCE_TOUT_RST  = 16'hFFFF;
  localparam logic [15:0] RESET_TAIL_RST     = 16'd500;
  localparam logic [7:0]  SLOT_LOW_RST       = 8'd5;
  localparam logic [7:0]  SLOT_HOLD_RST      = 8'd65;
  localparam logic [7:0]  READ_SAMPLE_RST    = 8'd5;

  localparam logic [15:0] WRITE_GAP_US = 16'd2;
  localparam logic [3:0]  BYTE_BITS    = 4'd8;

  typedef enum logic [12:0] {
    PH_IDLE   = 13'h0001,
    PH_R_PRE  = 13'h0002,
    PH_R_LOW  = 13'h0004,
    PH_R_WAIT = 13'h0008,
    PH_R_POLL = 13'h0010,
    PH_R_TAIL = 13'h0020,
    PH_W_LOW  = 13'h0040,
    PH_W_HOLD = 13'h0080,
    PH_W_GAP  = 13'h0100,
    PH_D_PRE  = 13'h0200,
    PH_D_LOW  = 13'h0400,
    PH_D_REL  = 13'h0800,
    PH_D_TAIL = 13'h1000
  } phase_t;

  typedef struct packed {
    logic [1:0] req_type;
    logic [7:0] tx_byte;
    logic       line_in;
  } in_item_t;

  typedef struct packed {
    logic       drive_low;
    logic       busy_res;
    logic       done_res;
    logic       presence;
    logic [7:0] rx_byte;
  } out_item_t;

  typedef struct packed {
    logic [15:0] pre_reset_us;
    logic [15:0] reset_low_us;
    logic [15:0] presence_delay_us;
    logic [15:0] presence_timeout;
    logic [15:0] reset_tail_us;
    logic [7:0]  slot_low_us;
    logic [7:0]  slot_hold_us;
    logic [7:0]  read_sample_us;
  } cfg_t;

endpackage

FILE: hdl/onewire_bus_master_unit.sv
// One-wire bus master, stepped by one-microsecond tick transfers.
// Result path: each input transfer passes the input register, then the result register.
// Throughput: one transfer per cycle while out_stall is low; sequence state updates once per item.
// Reset (rst, synchronous, active high): sequencer idle, bus released, config registers
// at their default timings, both pipeline registers empty.
module onewire_bus_master_unit
  import owbm_pkg::*;
#(
  parameter int unsigned TIMER_WIDTH = TIMER_WIDTH_DEF
) (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   cfg_we,
  input  logic [CFG_INDEX_W-1:0] cfg_index,
  input  logic [CFG_DATA_W-1:0]  cfg_data,
  input  logic                   in_valid,
  output logic                   in_stall,
  input  in_item_t               in_item,
  output logic                   out_valid,
  input  logic                   out_stall,
  output out_item_t              out_item
);

  cfg_t      cfg;
  logic      s1_valid;
  in_item_t  s1_item;
  logic      advance;
  out_item_t result;

  assign advance  = s1_valid && (!out_valid || !out_stall);
  assign in_stall = s1_valid && !advance;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.pre_reset_us      <= PRE_RESET_RST;
      cfg.reset_low_us      <= RESET_LOW_RST;
      cfg.presence_delay_us <= PRESENCE_DELAY_RST;
      cfg.presence_timeout  <= PRESENCE_TOUT_RST;
      cfg.reset_tail_us     <= RESET_TAIL_RST;
      cfg.slot_low_us       <= SLOT_LOW_RST;
      cfg.slot_hold_us      <= SLOT_HOLD_RST;
      cfg.read_sample_us    <= READ_SAMPLE_RST;
    end else if (cfg_we) begin
      case (cfg_index)
        CFG_PRE_RESET:      cfg.pre_reset_us      <= cfg_data;
        CFG_RESET_LOW:      cfg.reset_low_us      <= cfg_data;
        CFG_PRESENCE_DELAY: cfg.presence_delay_us <= cfg_data;
        CFG_PRESENCE_TOUT:  cfg.presence_timeout  <= cfg_data;
        CFG_RESET_TAIL:     cfg.reset_tail_us     <= cfg_data;
        CFG_SLOT_LOW:       cfg.slot_low_us       <= cfg_data[7:0];
        CFG_SLOT_HOLD:      cfg.slot_hold_us      <= cfg_data[7:0];
        CFG_READ_SAMPLE:    cfg.read_sample_us    <= cfg_data[7:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (in_valid && !in_stall) begin
      s1_valid <= 1'b1;
    end else if (advance) begin
      s1_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && !in_stall) begin
      s1_item <= in_item;
    end
  end

  owbm_seq #(
    .TIMER_WIDTH(TIMER_WIDTH)
  ) u_seq (
    .clk    (clk),
    .rst    (rst),
    .cfg    (cfg),
    .step_en(advance),
    .item   (s1_item),
    .result (result)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (advance) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      out_item <= result;
    end
  end

`ifndef SYNTHESIS
  a_done_idle: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_item.done_res |-> !out_item.busy_res && !out_item.drive_low)
    else $error("done result while sequence still busy or driving");

  a_no_stall_empty: assert property (@(posedge clk) disable iff (rst)
    !out_valid |-> !in_stall)
    else $error("input stalled while result register empty");

  a_advance_fills: assert property (@(posedge clk) disable iff (rst)
    advance |=> out_valid)
    else $error("advanced item did not reach result register");

  a_reset_empty: assert property (@(posedge clk)
    rst |=> !out_valid && !in_stall)
    else $error("pipeline not empty after reset");
`endif

endmodule

FILE: hdl/owbm_seq.sv
module owbm_seq
  import owbm_pkg::*;
#(
  parameter int unsigned TIMER_WIDTH = TIMER_WIDTH_DEF
) (
  input  logic      clk,
  input  logic      rst,
  input  cfg_t      cfg,
  input  logic      step_en,
  input  in_item_t  item,
  output out_item_t result
);

  localparam int unsigned LoadW       = (TIMER_WIDTH > 16) ? TIMER_WIDTH : 16;
  localparam int unsigned SettleSteps = 5;
  localparam logic [LoadW-1:0] TimeMax = LoadW'((33'd1 << TIMER_WIDTH) - 33'd1);

  typedef struct packed {
    phase_t                 phase;
    logic [TIMER_WIDTH-1:0] time_left;
    logic [3:0]             bits_left;
    logic [7:0]             shift_reg;
    logic                   line_drive;
    logic [7:0]             rx_last;
    logic                   done;
  } seq_t;

  phase_t                 phase;
  logic [TIMER_WIDTH-1:0] time_left;
  logic [3:0]             bits_left;
  logic [7:0]             shift_reg;
  logic                   line_drive;
  logic [7:0]             rx_last;
  logic                   presence_seen;

  seq_t seq_cur;
  seq_t seq_next;
  logic presence_next;

  function automatic logic [TIMER_WIDTH-1:0] sat_load(input logic [15:0] dur);
    logic [LoadW-1:0] d;
    d = LoadW'(dur);
    if (d > TimeMax) begin
      d = TimeMax;
    end
    return d[TIMER_WIDTH-1:0];
  endfunction

  function automatic seq_t enter_ph(input seq_t s, input phase_t ph,
                                    input logic [15:0] dur, input logic drv);
    seq_t r;
    r = s;
    r.phase = ph;
    r.time_left = sat_load(dur);
    r.line_drive = drv;
    return r;
  endfunction

  function automatic seq_t finish(input seq_t s, input logic line, input cfg_t c);
    seq_t       r;
    logic [3:0] bl;
    logic [7:0] sh;
    r = s;
    bl = s.bits_left - 4'd1;
    sh = s.shift_reg >> s.bits_left;
    case (s.phase)
      PH_R_PRE:  r = enter_ph(s, PH_R_LOW, c.reset_low_us, 1'b1);
      PH_R_LOW:  r = enter_ph(s, PH_R_WAIT, c.presence_delay_us, 1'b0);
      PH_R_WAIT: r = enter_ph(s, PH_R_POLL, c.presence_timeout, 1'b0);
      PH_R_POLL: r = enter_ph(s, PH_R_TAIL, c.reset_tail_us, 1'b0);
      PH_W_LOW:  r = enter_ph(s, PH_W_HOLD, {8'd0, c.slot_hold_us}, ~s.shift_reg[0]);
      PH_W_HOLD: r = enter_ph(s, PH_W_GAP, WRITE_GAP_US, 1'b0);
      PH_W_GAP: begin
        r.shift_reg = s.shift_reg >> 1;
        r.bits_left = bl;
        if (bl == 4'd0) begin
          r = enter_ph(r, PH_IDLE, 16'd0, 1'b0);
          r.done = 1'b1;
        end else begin
          r = enter_ph(r, PH_W_LOW, {8'd0, c.slot_low_us}, 1'b1);
        end
      end
      PH_D_PRE:  r = enter_ph(s, PH_D_LOW, {8'd0, c.slot_low_us}, 1'b1);
      PH_D_LOW: begin
        if (c.slot_low_us == 8'd0 && c.read_sample_us == 8'd0 &&
            c.slot_hold_us == 8'd0) begin
          // remaining slots all sample this same line level
          if (line) begin
            sh = sh | ~(8'hFF >> s.bits_left);
          end
          r.shift_reg = sh;
          r.bits_left = 4'd0;
          r.rx_last = sh;
          r = enter_ph(r, PH_IDLE, 16'd0, 1'b0);
          r.done = 1'b1;
        end else begin
          r = enter_ph(s, PH_D_REL, {8'd0, c.read_sample_us}, 1'b0);
        end
      end
      PH_D_REL: begin
        r.shift_reg = {line, s.shift_reg[7:1]};
        r = enter_ph(r, PH_D_TAIL, {8'd0, c.slot_hold_us}, 1'b0);
      end
      PH_D_TAIL: begin
        r.bits_left = bl;
        if (bl == 4'd0) begin
          r.rx_last = s.shift_reg;
          r = enter_ph(r, PH_IDLE, 16'd0, 1'b0);
          r.done = 1'b1;
        end else begin
          r = enter_ph(r, PH_D_LOW, {8'd0, c.slot_low_us}, 1'b1);
        end
      end
      default: begin
        r = enter_ph(s, PH_IDLE, 16'd0, 1'b0);
        r.done = 1'b1;
      end
    endcase
    return r;
  endfunction

  always_comb begin
    seq_cur.phase      = phase;
    seq_cur.time_left  = time_left;
    seq_cur.bits_left  = bits_left;
    seq_cur.shift_reg  = shift_reg;
    seq_cur.line_drive = line_drive;
    seq_cur.rx_last    = rx_last;
    seq_cur.done       = 1'b0;
  end

  always_comb begin
    seq_next = seq_cur;
    presence_next = presence_seen;
    if (item.req_type == REQ_TICK) begin
      if (seq_cur.phase != PH_IDLE) begin
        if (seq_cur.phase == PH_R_POLL && !item.line_in) begin
          presence_next = 1'b1;
          seq_next.time_left = '0;
        end else if (seq_cur.time_left != '0) begin
          seq_next.time_left = seq_cur.time_left - TIMER_WIDTH'(1);
        end
      end
    end else if (seq_cur.phase == PH_IDLE) begin
      if (item.req_type == REQ_RESET) begin
        presence_next = 1'b0;
        seq_next = enter_ph(seq_next, PH_R_PRE, cfg.pre_reset_us, 1'b0);
      end else if (item.req_type == REQ_WRITE) begin
        seq_next.shift_reg = item.tx_byte;
        seq_next.bits_left = BYTE_BITS;
        seq_next = enter_ph(seq_next, PH_W_LOW, {8'd0, cfg.slot_low_us}, 1'b1);
      end else begin
        seq_next.shift_reg = 8'd0;
        seq_next.bits_left = BYTE_BITS;
        seq_next = enter_ph(seq_next, PH_D_PRE, {8'd0, cfg.slot_low_us}, 1'b0);
      end
    end
    for (int i = 0; i < SettleSteps; i++) begin
      if (seq_next.phase != PH_IDLE && seq_next.time_left == '0) begin
        seq_next = finish(seq_next, item.line_in, cfg);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase         <= PH_IDLE;
      time_left     <= '0;
      bits_left     <= 4'd0;
      shift_reg     <= 8'd0;
      line_drive    <= 1'b0;
      rx_last       <= 8'd0;
      presence_seen <= 1'b0;
    end else if (step_en) begin
      phase         <= seq_next.phase;
      time_left     <= seq_next.time_left;
      bits_left     <= seq_next.bits_left;
      shift_reg     <= seq_next.shift_reg;
      line_drive    <= seq_next.line_drive;
      rx_last       <= seq_next.rx_last;
      presence_seen <= presence_next;
    end
  end

  always_comb begin
    result.drive_low = seq_next.line_drive;
    result.busy_res  = (seq_next.phase != PH_IDLE);
    result.done_res  = seq_next.done;
    result.presence  = presence_next;
    result.rx_byte   = seq_next.rx_last;
  end

endmodule
